@@ design/lcdns_pkg.sv @@
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcdns_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int FUNC_W    = 3;
   localparam int CHAR_W    = 8;
   localparam int COL_W     = 6;
   localparam int ROW_W     = 3;
   localparam int NIB_W     = 4;
   localparam int BEFORE_W  = 15;
   localparam int AFTER_W   = 13;
   localparam int LEN_W     = 6;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 6;
   localparam int STEP_W    = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT    = 3'd0,
      FUNC_PUTC    = 3'd1,
      FUNC_GOTO    = 3'd2,
      FUNC_SHIFT_R = 3'd3,
      FUNC_SHIFT_L = 3'd4
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_LENGTH = 1'd0,
      CSR_LINES_MODE  = 1'd1
   } csr_index_type;

   localparam logic [CHAR_W-1:0] CH_FORM_FEED = 8'd12;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_CURSOR_L   = 8'h10;
   localparam logic [7:0] CMD_SHIFT_R    = 8'h1C;
   localparam logic [7:0] CMD_SHIFT_L    = 8'h18;
   localparam logic [7:0] CMD_FUNC_SET   = 8'h20;
   localparam logic [7:0] ROW1_BASE      = 8'h80;
   localparam logic [7:0] ROW2_BASE      = 8'hC0;

   localparam logic [NIB_W-1:0] NIB_WAKE   = 4'h3;
   localparam logic [NIB_W-1:0] NIB_4BIT   = 4'h2;

   localparam logic [BEFORE_W-1:0] POWER_ON_US  = 15'd25000;
   localparam logic [AFTER_W-1:0]  WAKE_GAP_US  = 13'd6000;
   localparam logic [AFTER_W-1:0]  CMD_WAIT_US  = 13'd2000;
   localparam logic [AFTER_W-1:0]  CLEAR_WAIT_US = 13'd4000;
   localparam logic [AFTER_W-1:0]  DATA_WAIT_US = 13'd200;

   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;
   localparam logic [STEP_W-1:0] INIT_BYTE_STEP = 4'd4;

   localparam logic [LEN_W-1:0]  LINE_LENGTH_RESET = 6'd16;
   localparam logic [MODE_W-1:0] LINES_MODE_RESET  = 2'd2;

   typedef enum logic {
      ENT_INIT,
      ENT_BYTE
   } entry_kind_type;

   // One queued job: either the whole init run or a single byte
   typedef struct packed {
      entry_kind_type       kind;
      logic                 rs;
      logic [7:0]           data;
      logic [AFTER_W-1:0]   after;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } back_state_type;

endpackage

@@ design/lcdns_front.sv @@
// Front end: configuration registers, command accept and classification.
// Depends on lcdns_pkg; pushes one job per known command into lcdns_queue.
`timescale 1ns / 1ps

module lcdns_front
   import lcdns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_W-1:0]      req_column,
   input  logic [ROW_W-1:0]      req_row,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata,
   input  queue_status_type      q_status,
   output logic                  busy,
   output logic                  push,
   output entry_type             push_entry
);

   logic [LEN_W-1:0]  line_length_ff, line_length_in;
   logic [MODE_W-1:0] lines_mode_ff, lines_mode_in;
   logic              known_func;
   logic [7:0]        row_base;
   logic [7:0]        goto_addr;

   always_comb begin
      line_length_in = line_length_ff;
      lines_mode_in  = lines_mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_LENGTH: line_length_in = csr_wdata[LEN_W-1:0];
            CSR_LINES_MODE:  lines_mode_in  = csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RESET;
         lines_mode_ff  <= LINES_MODE_RESET;
      end else begin
         line_length_ff <= line_length_in;
         lines_mode_ff  <= lines_mode_in;
      end
   end

   // rows outside one to four fall back to row one
   always_comb begin
      unique case (req_row)
         3'd2:    row_base = ROW2_BASE;
         3'd3:    row_base = ROW1_BASE + {2'b00, line_length_ff};
         3'd4:    row_base = ROW2_BASE + {2'b00, line_length_ff};
         default: row_base = ROW1_BASE;
      endcase
   end

   assign goto_addr = (row_base + {2'b00, req_column} - 8'd1) | ROW1_BASE;

   always_comb begin
      known_func       = 1'b1;
      push_entry.kind  = ENT_BYTE;
      push_entry.rs    = 1'b0;
      push_entry.data  = CMD_CLEAR;
      push_entry.after = CMD_WAIT_US;
      unique case (req_func)
         FUNC_INIT: begin
            push_entry.kind = ENT_INIT;
            push_entry.data = CMD_FUNC_SET | {4'h0, lines_mode_ff, 2'b00};
         end
         FUNC_PUTC: begin
            priority if (req_char_code == CH_FORM_FEED) begin
               push_entry.after = CLEAR_WAIT_US;
            end else if (req_char_code == CH_NEWLINE) begin
               push_entry.data = ROW2_BASE;
            end else if (req_char_code == CH_BACKSPACE) begin
               push_entry.data = CMD_CURSOR_L;
            end else begin
               push_entry.rs    = 1'b1;
               push_entry.data  = req_char_code;
               push_entry.after = DATA_WAIT_US;
            end
         end
         FUNC_GOTO:    push_entry.data = goto_addr;
         FUNC_SHIFT_R: push_entry.data = CMD_SHIFT_R;
         FUNC_SHIFT_L: push_entry.data = CMD_SHIFT_L;
         default:      known_func = 1'b0;
      endcase
   end

   assign busy = q_status.full;
   // drop unknown commands: they produce no transfer
   assign push = start && !q_status.full && known_func;

endmodule

@@ design/lcdns_queue.sv @@
// Short job queue between the front end and the nibble back end.
// Depends on lcdns_pkg for the job type.
`timescale 1ns / 1ps

module lcdns_queue
   import lcdns_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

@@ design/lcdns_back.sv @@
// Back end: steps through a queued job and emits one nibble per cycle.
// Depends on lcdns_pkg; takes jobs from lcdns_queue.
`timescale 1ns / 1ps

module lcdns_back
   import lcdns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             head,
   input  queue_status_type      q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [NIB_W-1:0]      rsp_nibble,
   output logic                  rsp_reg_select,
   output logic [BEFORE_W-1:0]   rsp_wait_before_us,
   output logic [AFTER_W-1:0]    rsp_wait_after_us,
   output logic                  rsp_last
);

   back_state_type       state_ff, state_in;
   entry_type            cur_ff, cur_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 emit;
   logic                 at_last;
   logic [1:0]           init_byte_idx;
   logic [7:0]           init_byte;
   logic [NIB_W-1:0]     nib;
   logic                 nib_rs;
   logic [BEFORE_W-1:0]  nib_before;
   logic [AFTER_W-1:0]   nib_after;

   logic                 valid_ff;
   logic [NIB_W-1:0]     nibble_ff;
   logic                 rs_ff;
   logic [BEFORE_W-1:0]  before_ff;
   logic [AFTER_W-1:0]   after_ff;
   logic                 last_ff;

   assign at_last = (cur_ff.kind == ENT_INIT) ? (step_ff == INIT_LAST_STEP)
                                              : (step_ff == BYTE_LAST_STEP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_status.empty) state_in = BK_RUN;
         BK_RUN:  if (at_last && q_status.empty) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // fetch the next job on the final nibble so runs follow without a gap
   always_comb begin
      emit = 1'b0;
      pop  = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop = !q_status.empty;
         BK_RUN: begin
            emit = 1'b1;
            pop  = at_last && !q_status.empty;
         end
         default: ;
      endcase
   end

   always_comb begin
      cur_in  = pop ? head : cur_ff;
      step_in = pop ? '0 : (emit ? step_ff + 1'b1 : step_ff);
   end

   assign init_byte_idx = 2'((step_ff - INIT_BYTE_STEP) >> 1);

   always_comb begin
      unique case (init_byte_idx)
         2'd0:    init_byte = cur_ff.data;
         2'd1:    init_byte = CMD_DISPLAY_ON;
         2'd2:    init_byte = CMD_CLEAR;
         default: init_byte = CMD_ENTRY_MODE;
      endcase
   end

   always_comb begin
      nib_before = '0;
      nib_after  = '0;
      nib_rs     = 1'b0;
      if (cur_ff.kind == ENT_INIT) begin
         if (step_ff < INIT_BYTE_STEP) begin
            nib = (step_ff == 4'd3) ? NIB_4BIT : NIB_WAKE;
            if (step_ff == 4'd0) nib_before = POWER_ON_US;
            if (step_ff < 4'd3)  nib_after  = WAKE_GAP_US;
         end else begin
            // even steps carry the high nibble
            nib = step_ff[0] ? init_byte[3:0] : init_byte[7:4];
            if (step_ff[0]) nib_after = CMD_WAIT_US;
         end
      end else begin
         nib    = step_ff[0] ? cur_ff.data[3:0] : cur_ff.data[7:4];
         nib_rs = cur_ff.rs;
         if (step_ff[0]) nib_after = cur_ff.after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      nibble_ff <= nib;
      rs_ff     <= nib_rs;
      before_ff <= nib_before;
      after_ff  <= nib_after;
      last_ff   <= at_last;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_nibble         = nibble_ff;
   assign rsp_reg_select     = rs_ff;
   assign rsp_wait_before_us = before_ff;
   assign rsp_wait_after_us  = after_ff;
   assign rsp_last           = last_ff;

endmodule

@@ design/char_lcd_nibble_sequencer.sv @@
// Top level of the character LCD nibble sequencer.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue and lcdns_back.
//
// Usage:
//   Commands enter on req_* and are taken at a clock edge with start high
//   and busy low. busy is high while the job queue is full. Unknown
//   commands are taken and dropped without any transfer.
//   Each command becomes a run of nibble transfers on rsp_*, one cycle
//   each, marked by rsp_valid; rsp_last flags the final nibble of a run.
//   Init gives 12 nibbles, every other command gives 2.
//   A command taken into an empty block passes the queue, the back end's
//   job register and its output register before its first nibble appears.
//   The back end emits one nibble per cycle and moves straight on to the
//   next queued job, stepped through each run by its nibble step counter.
//   The csr_* port writes line_length (index 0) and display_lines_mode
//   (index 1); write only while the block is idle.
//   Reset (synchronous) empties the queue, stops any run and restores
//   line_length to 16 and display_lines_mode to 2.
//   The receiver cannot stall: every nibble is shown for one cycle only.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer
   import lcdns_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_W-1:0]      req_column,
   input  logic [ROW_W-1:0]      req_row,
   output logic                  rsp_valid,
   output logic [NIB_W-1:0]      rsp_nibble,
   output logic                  rsp_reg_select,
   output logic [BEFORE_W-1:0]   rsp_wait_before_us,
   output logic [AFTER_W-1:0]    rsp_wait_after_us,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head;
   logic             push;
   logic             pop;

   lcdns_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_column    (req_column),
      .req_row       (req_row),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_status      (q_status),
      .busy          (busy),
      .push          (push),
      .push_entry    (push_entry)
   );

   lcdns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   lcdns_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_nibble         (rsp_nibble),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_wait_after_us  (rsp_wait_after_us),
      .rsp_last           (rsp_last)
   );

endmodule
